// ===== hw/rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  // Fixed widths of the transaction fields.
  localparam int HueW = 16;
  localparam int SatW = 9;
  localparam int RgbW = 24;
  localparam int ChanW = 8;

  // Fraction bits of saturation and value; 1.0 is One.
  localparam int FracBits = 8;
  localparam int One = 1 << FracBits;

  // Clamped saturation/value width and the width used for the clamp compare.
  localparam int SvW = FracBits + 1;
  localparam int ExtW = (SatW > SvW) ? SatW : SvW;

  // Chroma and offset are at most One * One.
  localparam int ChromaW = 2 * FracBits + 1;
  // Channel sums are at most 60 * One * One.
  localparam int SumW = ChromaW + 6;
  localparam int ScaledW = SumW + 8;
  // 60 * One * One = 15 * 2^(2 * FracBits + 2).
  localparam int DivShift = 2 * FracBits + 2;
  localparam int XW = ScaledW - DivShift;

  localparam int HueFull = 360;
  localparam int SectorDeg = 60;
  localparam int ChanMax = 255;

  // Hue modulo 360 by reciprocal: floor(2^24 / 360), quotient is at most one low.
  localparam int ModShift = 24;
  localparam int ModRecip = (1 << ModShift) / HueFull;
  localparam int ModProdW = HueW + 16;
  localparam int ModQuoW = 8;
  localparam int ModRemW = HueW + 1;

  // Division by 15 by reciprocal: floor(2^16 / 15), quotient is at most one low.
  localparam int Div15 = 15;
  localparam int Div15Shift = 16;
  localparam int Div15Recip = (1 << Div15Shift) / Div15;
  localparam int Div15ProdW = XW + 13;
  localparam int Div15QuoW = Div15ProdW - Div15Shift;

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

endpackage

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// HSV to packed RGB color converter.
// Input transaction: hue_degrees_i (any 16-bit value, reduced modulo 360),
// saturation_i and brightness_i (fixed point, 256 = 1.0, larger values are
// clamped to 1.0). A transaction is taken at a rising edge with start_i
// high and busy_o low; busy_o is always low, so one transaction can be
// started in every cycle.
// Result transaction: rgb_packed_o (red 23:16, green 15:8, blue 7:0) is
// shown for one cycle with done_o high. Results come out in input order.
// The block is a six-stage pipeline: input multiplies,
// hue modulo, sector decode, channel sums, scaling by 255 with the
// reciprocal multiply for 1/15, and the final correction.
// Throughput is one transaction per clock.
// The receiver cannot stall the block, so the pipeline never holds.
// Reset clears the stage valid bits; no result appears until a new
// transaction has passed through all stages.
module hsv_to_rgb_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [hsv2rgb_pkg::HueW-1:0]  hue_degrees_i,
  input  logic [hsv2rgb_pkg::SatW-1:0]  saturation_i,
  input  logic [hsv2rgb_pkg::SatW-1:0]  brightness_i,
  output logic                          done_o,
  output logic [hsv2rgb_pkg::RgbW-1:0]  rgb_packed_o
);
  import hsv2rgb_pkg::*;

  logic [5:0] vld_q, vld_d;

  // Stage 1
  logic [HueW-1:0]     hue_q;
  logic [ModProdW-1:0] hue_prod_q;
  logic [ChromaW-1:0]  chroma1_q, offset1_q;
  logic [ExtW-1:0]     sat_ext, val_ext;
  logic [SvW-1:0]      sat_cl, val_cl;
  logic [2*SvW-1:0]    chroma_full, offset_full;

  // Stage 2
  logic [8:0]          h_q;
  logic [ChromaW-1:0]  chroma2_q, offset2_q;
  logic [ModQuoW-1:0]  mod_quo;
  logic [ModRemW-1:0]  mod_rem, mod_fix;

  // Stage 3
  sector_e             sector_d, sector_q;
  logic [5:0]          t_d, t_q;
  logic [8:0]          base_deg, h_in_sec;
  logic [ChromaW-1:0]  chroma3_q, offset3_q;

  // Stage 4
  logic [2:0][SumW-1:0] sum_d, sum_q;
  logic [SumW-1:0]      full_p, ramp_p, off_p;

  // Stage 5
  logic [2:0][XW-1:0]         x_d, x_q;
  logic [2:0][Div15ProdW-1:0] qp_d, qp_q;
  logic [2:0][ScaledW-1:0]    scaled;

  // Stage 6
  logic [RgbW-1:0]            rgb_d, rgb_q;
  logic [2:0][Div15QuoW-1:0]  quo;
  logic [2:0][XW-1:0]         rem;
  logic [2:0][ChanW-1:0]      chan;

  assign busy_o = 1'b0;

  assign vld_d = {vld_q[4:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: clamp saturation and value, form chroma and offset, and start
  // the hue reciprocal multiply.
  always_comb begin
    sat_ext = ExtW'(saturation_i);
    val_ext = ExtW'(brightness_i);
    sat_cl = (sat_ext > ExtW'(One)) ? SvW'(One) : SvW'(sat_ext);
    val_cl = (val_ext > ExtW'(One)) ? SvW'(One) : SvW'(val_ext);
    chroma_full = (2*SvW)'(sat_cl) * (2*SvW)'(val_cl);
    offset_full = (2*SvW)'(SvW'(One) - sat_cl) * (2*SvW)'(val_cl);
  end

  always_ff @(posedge clk_i) begin
    hue_q      <= hue_degrees_i;
    hue_prod_q <= ModProdW'(hue_degrees_i) * ModProdW'(ModRecip);
    chroma1_q  <= ChromaW'(chroma_full);
    offset1_q  <= ChromaW'(offset_full);
  end

  // Stage 2: hue modulo 360 with one correction step.
  always_comb begin
    mod_quo = hue_prod_q[ModShift +: ModQuoW];
    mod_rem = ModRemW'(hue_q) - ModRemW'(mod_quo) * ModRemW'(HueFull);
    mod_fix = (mod_rem >= ModRemW'(HueFull)) ? mod_rem - ModRemW'(HueFull) : mod_rem;
  end

  always_ff @(posedge clk_i) begin
    h_q       <= mod_fix[8:0];
    chroma2_q <= chroma1_q;
    offset2_q <= offset1_q;
  end

  // Stage 3: sector and ramp weight. In even sectors the ramp rises with
  // the hue, in odd sectors it falls.
  always_comb begin
    if (h_q >= 9'(5 * SectorDeg)) begin
      sector_d = SecMagRed;
      base_deg = 9'(5 * SectorDeg);
    end else if (h_q >= 9'(4 * SectorDeg)) begin
      sector_d = SecBluMag;
      base_deg = 9'(4 * SectorDeg);
    end else if (h_q >= 9'(3 * SectorDeg)) begin
      sector_d = SecCynBlu;
      base_deg = 9'(3 * SectorDeg);
    end else if (h_q >= 9'(2 * SectorDeg)) begin
      sector_d = SecGrnCyn;
      base_deg = 9'(2 * SectorDeg);
    end else if (h_q >= 9'(SectorDeg)) begin
      sector_d = SecYelGrn;
      base_deg = 9'(SectorDeg);
    end else begin
      sector_d = SecRedYel;
      base_deg = '0;
    end
    h_in_sec = h_q - base_deg;
    if (sector_d[0]) begin
      t_d = 6'(SectorDeg) - h_in_sec[5:0];
    end else begin
      t_d = h_in_sec[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q  <= sector_d;
    t_q       <= t_d;
    chroma3_q <= chroma2_q;
    offset3_q <= offset2_q;
  end

  // Stage 4: place full chroma, ramp and zero on the channels, add offset.
  // Everything is in units of 1 / (60 * One * One).
  always_comb begin
    full_p = SumW'(chroma3_q) * SumW'(SectorDeg);
    ramp_p = SumW'(chroma3_q) * SumW'(t_q);
    off_p  = SumW'(offset3_q) * SumW'(SectorDeg);
    case (sector_q)
      SecRedYel: begin
        sum_d[2] = full_p; sum_d[1] = ramp_p; sum_d[0] = '0;
      end
      SecYelGrn: begin
        sum_d[2] = ramp_p; sum_d[1] = full_p; sum_d[0] = '0;
      end
      SecGrnCyn: begin
        sum_d[2] = '0; sum_d[1] = full_p; sum_d[0] = ramp_p;
      end
      SecCynBlu: begin
        sum_d[2] = '0; sum_d[1] = ramp_p; sum_d[0] = full_p;
      end
      SecBluMag: begin
        sum_d[2] = ramp_p; sum_d[1] = '0; sum_d[0] = full_p;
      end
      default: begin
        sum_d[2] = full_p; sum_d[1] = '0; sum_d[0] = ramp_p;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = sum_d[i] + off_p;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Stage 5: scale by 255, drop the power-of-two part of the divisor and
  // start the reciprocal multiply for the remaining factor of 15.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled[i] = ScaledW'(sum_q[i]) * ScaledW'(ChanMax);
      x_d[i]    = scaled[i][DivShift +: XW];
      qp_d[i]   = Div15ProdW'(x_d[i]) * Div15ProdW'(Div15Recip);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    qp_q <= qp_d;
  end

  // Stage 6: the reciprocal quotient can be one low; fix it and pack.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = qp_q[i][Div15Shift +: Div15QuoW];
      rem[i] = x_q[i] - XW'(quo[i]) * XW'(Div15);
      if (rem[i] >= XW'(Div15)) begin
        chan[i] = ChanW'(quo[i] + Div15QuoW'(1));
      end else begin
        chan[i] = ChanW'(quo[i]);
      end
    end
    rgb_d = {chan[2], chan[1], chan[0]};
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign done_o       = vld_q[5];
  assign rgb_packed_o = rgb_q;

endmodule
